// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared constants for the sync frame receiver
// header bytes, payload length and field widths
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned PAYLOAD_BYTES = 2046;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned HDR_W  = 2;

  // out_tdata: data_byte, payload_position, computed_sum, zero padding
  localparam int unsigned OUT_FIELDS_W = BYTE_W + POS_W + SUM_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0] FINAL_BYTE = 8'h00;
  localparam logic [HDR_W-1:0]  SYNC_COUNT = 2'd3;

  // 3 * 0xaa + 0x00, the reversed header
  localparam logic [SUM_W-1:0] HEADER_SUM = 16'h01FE;

  localparam logic [POS_W:0] LAST_POS   = (POS_W+1)'(PAYLOAD_BYTES - 1);
  localparam logic [POS_W:0] CSUM_LO_POS = (POS_W+1)'(PAYLOAD_BYTES - 2);

endpackage : sfr_pkg

`default_nettype wire

// ===== rtl/sync_frame_receiver_bitrev_sum16.sv =====
// ----------------------------------------------------------------------------
// sync_frame_receiver_bitrev_sum16: sync word deframer with 16-bit sum
// hunts for 55 55 55 00, then emits bit-reversed payload bytes with checksum
// ----------------------------------------------------------------------------
`default_nettype none

// Takes one raw serial byte per word on the in_ stream. While hunting it looks
// for the header 55 55 55 00; a mismatching byte restarts the hunt and is not
// rechecked as a first header byte. After the header, each of the
// PAYLOAD_BYTES payload bytes comes out bit-reversed with its position and the
// running 16-bit sum (preloaded with the reversed header sum); the last two
// bytes are the little-endian received checksum and do not add to the sum.
// The final byte has out_tlast set and out_tuser carries the pass verdict.
// Header bytes produce no output word. One byte is taken every cycle; a byte
// lands in the input register when it is accepted and its result then moves on
// into the result register, and backpressure on out_ stalls both stages.
module sync_frame_receiver_bitrev_sum16 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [7:0] data_byte, [18:8] payload_position, [34:19] computed_sum, rest zero
  output logic [sfr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser   // [0] checksum_ok
);

  localparam int unsigned BW = sfr_pkg::BYTE_W;
  localparam int unsigned PW = sfr_pkg::POS_W;
  localparam int unsigned SW = sfr_pkg::SUM_W;

  // input register
  logic          in_vld_r;
  logic [BW-1:0] in_byte_r;

  // frame state
  logic                     in_payload_r, in_payload_nxt;
  logic [sfr_pkg::HDR_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [PW-1:0]            byte_cnt_r, byte_cnt_nxt;
  logic [SW-1:0]            sum_r, sum_nxt;
  logic [BW-1:0]            rcv_lo_r, rcv_lo_nxt;

  // result register
  logic          out_vld_r, out_vld_nxt;
  logic [BW-1:0] out_byte_r, out_byte_nxt;
  logic [PW-1:0] out_pos_r, out_pos_nxt;
  logic [SW-1:0] out_sum_r, out_sum_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ok_r, out_ok_nxt;

  logic          out_free;
  logic          proc;
  logic [BW-1:0] rev;
  logic [BW-1:0] expect_byte;
  logic          is_last;
  logic          is_csum_lo;

  assign out_free  = !out_vld_r || out_tready;
  assign proc      = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  always_comb begin
    for (int k = 0; k < BW; k++) begin
      rev[k] = in_byte_r[BW-1-k];
    end
  end

  assign expect_byte = (hdr_cnt_r < sfr_pkg::SYNC_COUNT) ? sfr_pkg::SYNC_BYTE
                                                        : sfr_pkg::FINAL_BYTE;
  assign is_last    = ({1'b0, byte_cnt_r} >= sfr_pkg::LAST_POS);
  assign is_csum_lo = ({1'b0, byte_cnt_r} == sfr_pkg::CSUM_LO_POS);

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    byte_cnt_nxt   = byte_cnt_r;
    sum_nxt        = sum_r;
    rcv_lo_nxt     = rcv_lo_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_pos_nxt    = out_pos_r;
    out_sum_nxt    = out_sum_r;
    out_last_nxt   = out_last_r;
    out_ok_nxt     = out_ok_r;

    if (proc) begin
      if (!in_payload_r) begin
        if (in_byte_r == expect_byte) begin
          if (hdr_cnt_r == sfr_pkg::SYNC_COUNT) begin
            hdr_cnt_nxt    = '0;
            in_payload_nxt = 1'b1;
            byte_cnt_nxt   = '0;
            sum_nxt        = sfr_pkg::HEADER_SUM;
            rcv_lo_nxt     = '0;
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 1'b1;
          end
        end else begin
          hdr_cnt_nxt = '0;
        end
      end else begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = rev;
        out_pos_nxt  = byte_cnt_r;
        out_last_nxt = is_last;
        out_ok_nxt   = 1'b0;
        out_sum_nxt  = sum_r;
        priority if (is_last) begin
          out_ok_nxt     = ({rev, rcv_lo_r} == sum_r);
          // back to hunting with everything at reset values
          in_payload_nxt = 1'b0;
          hdr_cnt_nxt    = '0;
          byte_cnt_nxt   = '0;
          sum_nxt        = sfr_pkg::HEADER_SUM;
          rcv_lo_nxt     = '0;
        end else if (is_csum_lo) begin
          rcv_lo_nxt   = rev;
          byte_cnt_nxt = byte_cnt_r + 1'b1;
        end else begin
          sum_nxt      = sum_r + SW'(rev);
          out_sum_nxt  = sum_r + SW'(rev);
          byte_cnt_nxt = byte_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= '0;
      byte_cnt_r   <= '0;
      sum_r        <= sfr_pkg::HEADER_SUM;
      rcv_lo_r     <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      sum_r        <= sum_nxt;
      rcv_lo_r     <= rcv_lo_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_sum_r  <= out_sum_nxt;
    out_last_r <= out_last_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(sfr_pkg::OUT_DATA_W - sfr_pkg::OUT_FIELDS_W){1'b0}},
                       out_sum_r, out_pos_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ok_r;

endmodule : sync_frame_receiver_bitrev_sum16

`default_nettype wire

// ===== tb/sfr_frame_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_frame_checker: output word predictor and comparator for the deframer
// tracks header hunting and payload state from accepted input words, queues
// the expected output words and compares them field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_frame_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [sfr_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [7:0] data_byte, [18:8] payload_position, [34:19] computed_sum, rest zero
  input  wire logic [sfr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           out_tlast,
  input  wire logic                           out_tuser,  // [0] checksum_ok
  output int                                  mismatches,
  output int                                  words_due
);

  localparam int unsigned BW = sfr_pkg::BYTE_W;
  localparam int unsigned PW = sfr_pkg::POS_W;
  localparam int unsigned SW = sfr_pkg::SUM_W;

  typedef struct packed {
    logic [BW-1:0] data_byte;
    logic [PW-1:0] position;
    logic          last;
    logic          csum_ok;
    logic [SW-1:0] sum;
  } payload_word_t;

  payload_word_t payload_words_q[$];

  logic                      in_frame;
  logic [sfr_pkg::HDR_W-1:0] sync_seen;
  logic [PW-1:0]             byte_cnt;
  logic [SW-1:0]             run_sum;
  logic [BW-1:0]             csum_lo;

  int fail_cnt = 0;
  int due_cnt  = 0;

  assign mismatches = fail_cnt;
  assign words_due  = due_cnt;

  function automatic logic [BW-1:0] mirror_byte(input logic [BW-1:0] b);
    logic [BW-1:0] r;
    for (int k = 0; k < BW; k++) r[k] = b[BW-1-k];
    return r;
  endfunction

  task automatic clear_frame();
    in_frame  = 1'b0;
    sync_seen = '0;
    byte_cnt  = '0;
    run_sum   = sfr_pkg::HEADER_SUM;
    csum_lo   = '0;
  endtask

  task automatic deframe_byte(input logic [BW-1:0] b);
    payload_word_t w;
    logic [BW-1:0] rev;
    logic [PW-1:0] pos;
    logic          fin;
    if (!in_frame) begin
      if (sync_seen < sfr_pkg::SYNC_COUNT) begin
        sync_seen = (b == sfr_pkg::SYNC_BYTE) ? sync_seen + 1'b1 : '0;
      end else begin
        // a mismatching byte here is dropped, not retried as a first sync byte
        sync_seen = '0;
        if (b == sfr_pkg::FINAL_BYTE) begin
          in_frame = 1'b1;
          byte_cnt = '0;
          run_sum  = sfr_pkg::HEADER_SUM;
          csum_lo  = '0;
        end
      end
    end else begin
      rev = mirror_byte(b);
      pos = byte_cnt;
      fin = ({1'b0, pos} >= sfr_pkg::LAST_POS);
      w.csum_ok = 1'b0;
      if (fin) begin
        w.csum_ok = ({rev, csum_lo} == run_sum);
      end else if ({1'b0, pos} == sfr_pkg::CSUM_LO_POS) begin
        csum_lo = rev;
      end else begin
        run_sum = run_sum + SW'(rev);
      end
      w.data_byte = rev;
      w.position  = pos;
      w.last      = fin;
      w.sum       = run_sum;
      payload_words_q.push_back(w);
      if (fin) begin
        clear_frame();
      end else begin
        byte_cnt = pos + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    payload_word_t exp_w;
    if (!rst_n) begin
      clear_frame();
      payload_words_q.delete();
    end else begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (payload_words_q.size() == 0) begin
          $error("unexpected output word %0h", out_tdata);
          fail_cnt++;
        end else begin
          exp_w = payload_words_q.pop_front();
          if (out_tdata[BW-1:0] != exp_w.data_byte) begin
            $error("data_byte: expected %0h, got %0h", exp_w.data_byte,
                   out_tdata[BW-1:0]);
            fail_cnt++;
          end
          if (out_tdata[BW +: PW] != exp_w.position) begin
            $error("payload_position: expected %0d, got %0d", exp_w.position,
                   out_tdata[BW +: PW]);
            fail_cnt++;
          end
          if (out_tdata[BW+PW +: SW] != exp_w.sum) begin
            $error("computed_sum: expected %0h, got %0h", exp_w.sum,
                   out_tdata[BW+PW +: SW]);
            fail_cnt++;
          end
          if (out_tlast != exp_w.last) begin
            $error("last: expected %0b, got %0b", exp_w.last, out_tlast);
            fail_cnt++;
          end
          if (out_tuser != exp_w.csum_ok) begin
            $error("checksum_ok: expected %0b, got %0b", exp_w.csum_ok, out_tuser);
            fail_cnt++;
          end
        end
      end
    end
    due_cnt <= payload_words_q.size();
  end

endmodule : sfr_frame_checker

// ===== tb/sync_frame_receiver_bitrev_sum16_tb.sv =====
// ----------------------------------------------------------------------------
// sync_frame_receiver_bitrev_sum16_tb: stimulus and verdict for the deframer
// drives header hunting cases, then one whole frame with a good or corrupted
// checksum followed by noise, with random idles on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_frame_receiver_bitrev_sum16_tb;

  localparam int unsigned BW = sfr_pkg::BYTE_W;
  localparam int unsigned SW = sfr_pkg::SUM_W;

  typedef enum int {CSUM_GOOD, CSUM_BAD_LO, CSUM_BAD_HI} csum_kind_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [BW-1:0]                  in_tdata;    // [7:0] rx_byte
  logic                           out_tvalid;
  logic                           out_tready;
  // [7:0] data_byte, [18:8] payload_position, [34:19] computed_sum, rest zero
  logic [sfr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           out_tuser;   // [0] checksum_ok

  int mismatches;
  int words_due;
  int sent_cnt = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;

  sync_frame_receiver_bitrev_sum16 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  sfr_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BW-1:0] swap_bit_order(input logic [BW-1:0] b);
    logic [BW-1:0] r;
    for (int k = 0; k < BW; k++) r[k] = b[BW-1-k];
    return r;
  endfunction

  task automatic send_byte(input logic [BW-1:0] b);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
    if (sent_cnt % 200 == 0) steady_in = ($urandom_range(0, 3) == 0);
    gap = 0;
    if (!steady_in && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // line noise heavy on sync-like bytes, never completing a header and
  // always ending on a byte that leaves the hunt at its start
  task automatic send_noise(input int n);
    logic [BW-1:0] b;
    int unsigned sel;
    int seen;
    seen = 0;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) b = sfr_pkg::SYNC_BYTE;
      else if (sel < 7) b = sfr_pkg::FINAL_BYTE;
      else b = BW'($urandom);
      if (i == n - 1) begin
        while (b == sfr_pkg::SYNC_BYTE || b == sfr_pkg::FINAL_BYTE) b = BW'($urandom);
      end
      if (seen == 3 && b == sfr_pkg::FINAL_BYTE) b = 8'h01;
      if (seen < 3) seen = (b == sfr_pkg::SYNC_BYTE) ? seen + 1 : 0;
      else seen = 0;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input csum_kind_t kind, input bit lead_extremes);
    logic [BW-1:0] b;
    logic [BW-1:0] lo_raw;
    logic [BW-1:0] hi_raw;
    logic [SW-1:0] sum;
    logic [BW-1:0] lead [4];
    lead[0] = 8'h00;
    lead[1] = 8'hFF;
    lead[2] = 8'h01;
    lead[3] = 8'h80;
    sum = sfr_pkg::HEADER_SUM;
    repeat (sfr_pkg::SYNC_COUNT) send_byte(sfr_pkg::SYNC_BYTE);
    send_byte(sfr_pkg::FINAL_BYTE);
    for (int pos = 0; pos < sfr_pkg::PAYLOAD_BYTES - 2; pos++) begin
      b = BW'($urandom);
      if (lead_extremes && pos < 4) b = lead[pos];
      sum = sum + SW'(swap_bit_order(b));
      send_byte(b);
    end
    lo_raw = swap_bit_order(sum[7:0]);
    hi_raw = swap_bit_order(sum[15:8]);
    if (kind == CSUM_BAD_LO) lo_raw ^= BW'(1) << $urandom_range(0, 7);
    if (kind == CSUM_BAD_HI) hi_raw ^= BW'(1) << $urandom_range(0, 7);
    send_byte(lo_raw);
    send_byte(hi_raw);
  endtask

  initial begin : out_ready_gen
    int unsigned stall;
    int unsigned cyc;
    stall = 0;
    cyc = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 500 == 0) steady_out = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (!steady_out && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall = pick_gap() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int wait_cnt;
    csum_kind_t kind;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hunting: extremes, header broken at the third byte, a fourth sync byte
    // that must not count as a new first one, then a clean return to start
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(sfr_pkg::SYNC_BYTE);
    send_byte(sfr_pkg::SYNC_BYTE);
    send_byte(sfr_pkg::FINAL_BYTE);
    repeat (4) send_byte(sfr_pkg::SYNC_BYTE);
    send_byte(sfr_pkg::SYNC_BYTE);
    send_byte(sfr_pkg::SYNC_BYTE);
    send_byte(sfr_pkg::FINAL_BYTE);
    send_byte(8'hAA);

    kind = csum_kind_t'($urandom_range(0, 2));
    send_frame(kind, 1'b1);
    send_noise($urandom_range(10, 80));
    in_tvalid <= 1'b0;

    @(posedge clk);
    wait_cnt = 0;
    while (words_due != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (words_due != 0) $error("%0d output words never arrived", words_due);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule : sync_frame_receiver_bitrev_sum16_tb
